[rtl/tsa_pkg.sv]
// ----------------------------------------------------------------------------
// Two-stream timestamp aligner package
// Shared constants, types and helper functions of the aligner.
// ----------------------------------------------------------------------------
package tsa_pkg;

   // Queue and handle sizing.
   localparam int QUEUE_DEPTH  = 16;
   localparam int HANDLE_BITS  = 16;
   localparam int ADDR_W       = $clog2(QUEUE_DEPTH);
   localparam int FILL_W       = $clog2(QUEUE_DEPTH + 1);

   // Fixed field widths.
   localparam int SPILL_W      = 16;
   localparam int RAW_W        = 16;
   localparam int TICK_W       = 24;
   localparam int PORT_HANDLE_W = 16;

   localparam logic [TICK_W-1:0]  TICK_WINDOW_RESET = 24'd10;
   localparam logic [SPILL_W-1:0] SPILL_MAX         = 16'hFFFF;
   localparam logic [RAW_W:0]     NO_SPILL          = 17'h1FFFF;

   // Result codes.
   typedef enum logic [1:0] {
      EMIT_BOTH = 2'd0,
      EMIT_A    = 2'd1,
      EMIT_B    = 2'd2,
      EMIT_NONE = 2'd3
   } emit_code_type;

   // Back-end sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_CMP
   } back_state_type;

   // One stored queue entry.
   typedef struct packed {
      logic [SPILL_W-1:0]     spill;
      logic [TICK_W-1:0]      ticks;
      logic [HANDLE_BITS-1:0] handle;
   } queue_entry_type;

   // One classified fragment as handed from the front to the back.
   typedef struct packed {
      queue_entry_type entry;
      logic            nonempty;
   } lane_frag_type;

   typedef struct packed {
      lane_frag_type a;
      lane_frag_type b;
   } cmd_type;

   // Port handle to stored handle width.
   function automatic logic [HANDLE_BITS-1:0] handle_to_store(
      input logic [PORT_HANDLE_W-1:0] h);
      logic [HANDLE_BITS-1:0] r;
      r = '0;
      for (int i = 0; i < HANDLE_BITS; i++) begin
         if (i < PORT_HANDLE_W) begin
            r[i] = h[i];
         end
      end
      return r;
   endfunction

   // Stored handle to port handle width.
   function automatic logic [PORT_HANDLE_W-1:0] handle_to_port(
      input logic [HANDLE_BITS-1:0] h);
      logic [PORT_HANDLE_W-1:0] r;
      r = '0;
      for (int i = 0; i < PORT_HANDLE_W; i++) begin
         if (i < HANDLE_BITS) begin
            r[i] = h[i];
         end
      end
      return r;
   endfunction

endpackage

[rtl/tsa_if.sv]
// ----------------------------------------------------------------------------
// Two-stream timestamp aligner channels
// Valid/ready interfaces of the fragment pair input and the result output.
// ----------------------------------------------------------------------------
interface tsa_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] raw_spill_a;
   logic [23:0] ticks_a;
   logic        nonempty_a;
   logic [15:0] in_handle_a;
   logic [15:0] raw_spill_b;
   logic [23:0] ticks_b;
   logic        nonempty_b;
   logic [15:0] in_handle_b;

   modport source (output valid, raw_spill_a, ticks_a, nonempty_a, in_handle_a,
                   raw_spill_b, ticks_b, nonempty_b, in_handle_b, input ready);
   modport sink   (input valid, raw_spill_a, ticks_a, nonempty_a, in_handle_a,
                   raw_spill_b, ticks_b, nonempty_b, in_handle_b, output ready);
endinterface

interface tsa_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  emit_code;
   logic [15:0] out_handle_a;
   logic [15:0] out_handle_b;
   logic        keep_hint;
   logic        overflow;

   modport source (output valid, emit_code, out_handle_a, out_handle_b, keep_hint,
                   overflow, input ready);
   modport sink   (input valid, emit_code, out_handle_a, out_handle_b, keep_hint,
                   overflow, output ready);
endinterface

[rtl/tsa_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/tsa_front.sv]
// ----------------------------------------------------------------------------
// Aligner front end
// Accepts fragment pairs, numbers spills per source and stages the item.
// ----------------------------------------------------------------------------
module tsa_front import tsa_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   tsa_req_if.sink   req_chan,
   output cmd_type   cmd_data,
   output logic      cmd_valid,
   input  logic      cmd_ready
);

   logic [SPILL_W-1:0] count_a_ff, count_a_in, count_b_ff, count_b_in;
   logic [RAW_W:0]     last_a_ff, last_a_in, last_b_ff, last_b_in;
   logic               cmd_valid_ff, cmd_valid_in;
   cmd_type            cmd_ff, cmd_in;
   logic               take;

   // The staging register frees up as soon as the back end takes it.
   assign req_chan.ready = !cmd_valid_ff || cmd_ready;
   assign take           = req_chan.valid && req_chan.ready;

   // Spill counting: a raw spill change bumps the saturating counter.
   always_comb begin
      count_a_in = count_a_ff;
      last_a_in  = last_a_ff;
      count_b_in = count_b_ff;
      last_b_in  = last_b_ff;
      if ({1'b0, req_chan.raw_spill_a} != last_a_ff) begin
         last_a_in = {1'b0, req_chan.raw_spill_a};
         if (count_a_ff != SPILL_MAX) begin
            count_a_in = count_a_ff + 1'b1;
         end
      end
      if ({1'b0, req_chan.raw_spill_b} != last_b_ff) begin
         last_b_in = {1'b0, req_chan.raw_spill_b};
         if (count_b_ff != SPILL_MAX) begin
            count_b_in = count_b_ff + 1'b1;
         end
      end
   end

   // Classified item for the back end.
   always_comb begin
      cmd_in.a.entry.spill  = count_a_in;
      cmd_in.a.entry.ticks  = req_chan.ticks_a;
      cmd_in.a.entry.handle = handle_to_store(req_chan.in_handle_a);
      cmd_in.a.nonempty     = req_chan.nonempty_a;
      cmd_in.b.entry.spill  = count_b_in;
      cmd_in.b.entry.ticks  = req_chan.ticks_b;
      cmd_in.b.entry.handle = handle_to_store(req_chan.in_handle_b);
      cmd_in.b.nonempty     = req_chan.nonempty_b;
      cmd_valid_in = take ? 1'b1 : (cmd_ready ? 1'b0 : cmd_valid_ff);
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_a_ff   <= '0;
         count_b_ff   <= '0;
         last_a_ff    <= NO_SPILL;
         last_b_ff    <= NO_SPILL;
         cmd_valid_ff <= 1'b0;
      end else begin
         cmd_valid_ff <= cmd_valid_in;
         if (take) begin
            count_a_ff <= count_a_in;
            count_b_ff <= count_b_in;
            last_a_ff  <= last_a_in;
            last_b_ff  <= last_b_in;
         end
      end
   end

   // Payload staging register.
   always_ff @(posedge clock) begin
      if (take) begin
         cmd_ff <= cmd_in;
      end
   end

   assign cmd_data  = cmd_ff;
   assign cmd_valid = cmd_valid_ff;

endmodule

[rtl/tsa_lane.sv]
// ----------------------------------------------------------------------------
// Aligner lane queue
// Circular FIFO of non-empty fragments for one source, held in a RAM.
// ----------------------------------------------------------------------------
module tsa_lane import tsa_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            push_en,
   input  queue_entry_type push_entry,
   input  logic            pop_en,
   output logic            drop,
   output logic            not_empty,
   output queue_entry_type head_entry
);

   logic [ADDR_W-1:0] head_ff, head_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [ADDR_W:0]   pos_sum;
   logic [ADDR_W-1:0] wr_addr;
   logic              full;
   logic              push_ok;
   logic [$bits(queue_entry_type)-1:0] rd_data;

   assign full      = fill_ff == FILL_W'(QUEUE_DEPTH);
   assign not_empty = fill_ff != '0;
   assign push_ok   = push_en && !full;
   assign drop      = push_en && full;

   // Tail slot: head plus fill, wrapped once.
   always_comb begin
      pos_sum = (ADDR_W+1)'(head_ff) + (ADDR_W+1)'(fill_ff);
      if (pos_sum >= (ADDR_W+1)'(QUEUE_DEPTH)) begin
         pos_sum = pos_sum - (ADDR_W+1)'(QUEUE_DEPTH);
      end
      wr_addr = pos_sum[ADDR_W-1:0];
   end

   // Pointer and fill updates.
   always_comb begin
      head_in = head_ff;
      fill_in = fill_ff;
      if (pop_en) begin
         head_in = (head_ff == ADDR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
      end
      if (push_ok && !pop_en) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop_en && !push_ok) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         fill_ff <= '0;
      end else begin
         head_ff <= head_in;
         fill_ff <= fill_in;
      end
   end

   // Entry storage; the head slot is read continuously.
   tsa_ram #(
      .WIDTH($bits(queue_entry_type)),
      .DEPTH(QUEUE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (push_ok),
      .wr_addr (wr_addr),
      .wr_data (push_entry),
      .rd_addr (head_ff),
      .rd_data (rd_data)
   );

   assign head_entry = queue_entry_type'(rd_data);

endmodule

[rtl/tsa_back.sv]
// ----------------------------------------------------------------------------
// Aligner back end
// Queues staged fragments, compares the two heads and emits one result.
// ----------------------------------------------------------------------------
module tsa_back import tsa_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd_data,
   input  logic               cmd_valid,
   output logic               cmd_ready,
   input  logic               csr_wr_en,
   input  logic [TICK_W-1:0]  csr_wr_data,
   tsa_rsp_if.source          rsp_chan
);

   back_state_type     state_ff, state_in;
   logic [TICK_W-1:0]  window_ff;
   logic               ovf_ff, ovf_in;
   logic               ovf_out_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   emit_code_type      code_ff, code_in;
   logic [PORT_HANDLE_W-1:0] ha_ff, ha_in, hb_ff, hb_in;
   logic               take, emit;
   logic               pop_a, pop_b;
   logic               drop_a, drop_b, ne_a, ne_b;
   queue_entry_type    head_a, head_b;
   logic [TICK_W-1:0]  gap;
   logic               same_spill, a_first;

   assign cmd_ready = state_ff == ST_IDLE;
   assign take      = cmd_valid && cmd_ready;
   assign emit      = (state_ff == ST_CMP) && (!rsp_valid_ff || rsp_chan.ready);

   // Source queues.
   tsa_lane u_lane_a (
      .clock      (clock),
      .reset      (reset),
      .push_en    (take && cmd_data.a.nonempty),
      .push_entry (cmd_data.a.entry),
      .pop_en     (pop_a),
      .drop       (drop_a),
      .not_empty  (ne_a),
      .head_entry (head_a)
   );

   tsa_lane u_lane_b (
      .clock      (clock),
      .reset      (reset),
      .push_en    (take && cmd_data.b.nonempty),
      .push_entry (cmd_data.b.entry),
      .pop_en     (pop_b),
      .drop       (drop_b),
      .not_empty  (ne_b),
      .head_entry (head_b)
   );

   // Head comparison.
   always_comb begin
      gap        = (head_a.ticks >= head_b.ticks) ? head_a.ticks - head_b.ticks
                                                  : head_b.ticks - head_a.ticks;
      same_spill = head_a.spill == head_b.spill;
      a_first    = same_spill ? (head_a.ticks < head_b.ticks)
                              : (head_a.spill < head_b.spill);
      code_in    = EMIT_NONE;
      if (ne_a && ne_b) begin
         if (same_spill && gap < window_ff) begin
            code_in = EMIT_BOTH;
         end else if (a_first) begin
            code_in = EMIT_A;
         end else begin
            code_in = EMIT_B;
         end
      end else if (ne_a) begin
         code_in = EMIT_A;
      end else if (ne_b) begin
         code_in = EMIT_B;
      end
      pop_a = emit && (code_in == EMIT_BOTH || code_in == EMIT_A);
      pop_b = emit && (code_in == EMIT_BOTH || code_in == EMIT_B);
      ha_in = (code_in == EMIT_BOTH || code_in == EMIT_A) ?
              handle_to_port(head_a.handle) : '0;
      hb_in = (code_in == EMIT_BOTH || code_in == EMIT_B) ?
              handle_to_port(head_b.handle) : '0;
   end

   // Sequencer: push, read heads, compare and emit.
   always_comb begin
      state_in     = state_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_chan.ready ? 1'b0 : rsp_valid_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               ovf_in   = drop_a || drop_b;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (emit) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         window_ff    <= TICK_WINDOW_RESET;
         ovf_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         ovf_ff       <= ovf_in;
         if (csr_wr_en) begin
            window_ff <= csr_wr_data;
         end
      end
   end

   // Result payload register. The overflow flag travels with its result, so
   // a stalled result keeps it while the next item is already being pushed.
   always_ff @(posedge clock) begin
      if (emit) begin
         code_ff    <= code_in;
         ha_ff      <= ha_in;
         hb_ff      <= hb_in;
         ovf_out_ff <= ovf_ff;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.emit_code    = code_ff;
   assign rsp_chan.out_handle_a = ha_ff;
   assign rsp_chan.out_handle_b = hb_ff;
   assign rsp_chan.keep_hint    = code_ff == EMIT_BOTH;
   assign rsp_chan.overflow     = ovf_out_ff;

endmodule

[rtl/two_stream_timestamp_aligner_top.sv]
// ----------------------------------------------------------------------------
// Two-stream timestamp aligner
// Each req_chan item carries one fragment from each of sources A and B. The
// block numbers spills per source, queues non-empty fragments in a 16-deep
// queue per source and answers every item with exactly one rsp_chan item:
// both heads merged, one head alone, or nothing left. A fragment pushed into
// a full queue is dropped and flagged in that item's overflow bit.
// The csr_wr_en / csr_wr_data port sets the tick window; write it only while
// no item is in flight.
// An accepted item passes the front-end staging register and then the back end's
// sequence of queue write, registered RAM read of the heads, and compare; the
// back end takes no new item until it has emitted the result of the last one.
// The front end holds one staged item, so it accepts the next item while the
// back end is still busy.
// Reset (synchronous) empties both queues, clears the spill counters and
// loads the tick window with 10. No memory clearing pass is needed.
// When the receiver stalls, the result register holds; the back end then
// stops and the front end fills up before req_chan.ready drops.
// ----------------------------------------------------------------------------
module two_stream_timestamp_aligner_top import tsa_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   tsa_req_if.sink           req_chan,
   tsa_rsp_if.source         rsp_chan,
   input  logic              csr_wr_en,
   input  logic [TICK_W-1:0] csr_wr_data
);

   cmd_type cmd_data;
   logic    cmd_valid;
   logic    cmd_ready;

   // Front end: accept and classify.
   tsa_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .cmd_data  (cmd_data),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready)
   );

   // Back end: queue, compare and emit.
   tsa_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_data    (cmd_data),
      .cmd_valid   (cmd_valid),
      .cmd_ready   (cmd_ready),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_chan    (rsp_chan)
   );

endmodule
